[rtl/core/cplm_pkg.sv]
// Package for the chunk pool list manager: sizes, opcodes, states and
// controller/datapath command and status types. No dependencies.
`default_nettype none
package cplm_pkg;
  localparam int POOL_DEPTH_DEF  = 16;
  localparam int NUM_LISTS_DEF   = 4;
  localparam int CHUNK_BYTES_DEF = 32768;

  localparam logic [2:0] OP_ALLOC    = 3'd0;
  localparam logic [2:0] OP_POP_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK = 3'd2;
  localparam logic [2:0] OP_PREPEND  = 3'd3;
  localparam logic [2:0] OP_TRANSFER = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;

  localparam logic CFG_CHUNK_COUNT = 1'b0;
  localparam logic CFG_BUFFER_BASE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ALLOC,
    ST_WALK,
    ST_EXEC,
    ST_WALK2,
    ST_EXEC2,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input item
    logic alloc_step;  // test one chunk for allocation
    logic walk_init;   // start a walk
    logic walk_step;   // one step along next links
    logic exec;        // perform link update (first phase)
    logic walk2_init;  // start second walk (destination tail)
    logic exec2;       // second phase update
    logic finish;      // result ready to be registered
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       sel_ok;     // list selector(s) valid for this op
    logic       alloc_done; // allocation found or exhausted
    logic       walk_done;  // walk reached tail or bound
    logic       need_walk;  // op needs first walk
    logic       need_walk2; // transfer needs destination walk
    logic       clear_more; // clear must pop again
  } sts_t;
endpackage
`default_nettype wire

[rtl/core/cplm_ctrl.sv]
// Controller state machine for the chunk pool list manager.
// Depends on cplm_pkg.
`default_nettype none
module cplm_ctrl
  import cplm_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  start,
  input  wire  out_free,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);
  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        if (sts.op == OP_ALLOC)        state_nxt = ST_ALLOC;
        else if (!sts.sel_ok)          state_nxt = ST_DONE;
        else if (sts.need_walk)        state_nxt = ST_WALK;
        else                           state_nxt = ST_EXEC;
      end
      ST_ALLOC:    if (sts.alloc_done) state_nxt = ST_DONE;
      ST_WALK:     if (sts.walk_done) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (sts.need_walk2)      state_nxt = ST_WALK2;
        else if (sts.clear_more) state_nxt = ST_EXEC;
        else                     state_nxt = ST_DONE;
      end
      ST_WALK2:    if (sts.walk_done) state_nxt = ST_EXEC2;
      ST_EXEC2:    state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:     cmd.load = start;
      ST_DISPATCH: cmd.walk_init = 1'b1;
      ST_ALLOC:    cmd.alloc_step = 1'b1;
      ST_WALK:     cmd.walk_step = 1'b1;
      ST_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.walk2_init = sts.need_walk2;
      end
      ST_WALK2:    cmd.walk_step = 1'b1;
      ST_EXEC2:    cmd.exec2 = 1'b1;
      ST_DONE:     cmd.finish = out_free;
      default:     cmd = '0;
    endcase
  end

  // a finish only follows a busy phase
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> busy) else $error("finish while idle");
  // a load from idle is followed by dispatch
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_DISPATCH)) else $error("load not followed by dispatch");
  // second walk only after exec
  a_walk2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK2) |-> ($past(state_r) == ST_EXEC || $past(state_r) == ST_WALK2))
    else $error("walk2 out of sequence");
endmodule
`default_nettype wire

[rtl/core/cplm_dp.sv]
// Datapath for the chunk pool list manager: link tables, marks, heads,
// rotor, walker and result register. Depends on cplm_pkg.
`default_nettype none
module cplm_dp
  import cplm_pkg::*;
#(
  parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
  parameter int NUM_LISTS   = NUM_LISTS_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)(
  input  wire         clk,
  input  wire         rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  wire  [2:0]  op_in,
  input  wire  [1:0]  list_in,
  input  wire  [1:0]  dest_in,
  input  wire  [3:0]  chunk_in,
  input  wire         cfg_we,
  input  wire         cfg_idx,
  input  wire  [31:0] cfg_data,
  output logic        res_found,
  output logic [3:0]  res_chunk,
  output logic [31:0] res_addr
);
  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam int HW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int SW = $clog2(POOL_DEPTH + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);
  localparam logic [31:0] CB = 32'(CHUNK_BYTES);

  logic [POOL_DEPTH-1:0] used_r, used_nxt;
  logic [LW-1:0] nxt_r [POOL_DEPTH];
  logic [LW-1:0] nxt_nxt [POOL_DEPTH];
  logic [LW-1:0] prv_r [POOL_DEPTH];
  logic [LW-1:0] prv_nxt [POOL_DEPTH];
  logic [LW-1:0] head_r [NUM_LISTS];
  logic [LW-1:0] head_nxt [NUM_LISTS];
  logic [IW-1:0] rotor_r, rotor_nxt;
  logic [4:0]    count_r;
  logic [31:0]   base_r;
  logic [2:0]    op_r;
  logic [1:0]    ls_r, dl_r;
  logic [3:0]    ci_r;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [LW-1:0] wpos_r, wpos_nxt;   // walker position
  logic [LW-1:0] tail_r, tail_nxt;   // source tail latched before walk2
  logic          found_r, found_nxt;
  logic [3:0]    chunk_r, chunk_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [SW-1:0] neff;

  function automatic logic vld(input logic [LW-1:0] c);
    return c < NIL;
  endfunction

  // effective chunk count
  always_comb begin
    if (count_r == 5'd0) neff = SW'(1);
    else if (32'(count_r) > 32'(POOL_DEPTH)) neff = SW'(POOL_DEPTH);
    else neff = SW'(count_r);
  end

  wire [HW-1:0] lsi = HW'(ls_r);
  wire [HW-1:0] dli = HW'(dl_r);
  wire          ls_ok = 32'(ls_r) < 32'(NUM_LISTS);
  wire          dl_ok = 32'(dl_r) < 32'(NUM_LISTS);
  wire [LW-1:0] hs = head_r[lsi];
  wire [LW-1:0] hd = head_r[dli];
  wire [LW-1:0] ci_l = LW'(ci_r);
  wire          ci_ok = 32'(ci_r) < 32'(POOL_DEPTH);
  wire [LW-1:0] wnext = nxt_r[wpos_r[IW-1:0]];
  wire          wend = !vld(wnext) || (steps_r == SW'(POOL_DEPTH));

  // status to controller
  always_comb begin
    sts.op = op_r;
    sts.sel_ok = (op_r <= OP_CLEAR) && ls_ok &&
                 ((op_r != OP_TRANSFER) || dl_ok) &&
                 ((op_r != OP_PREPEND) || ci_ok) &&
                 (((op_r != OP_POP_FRONT) && (op_r != OP_CLEAR) && (op_r != OP_PREPEND))
                  ? vld(hs) : 1'b1) &&
                 ((op_r != OP_CLEAR) || vld(hs));
    sts.need_walk = (op_r == OP_POP_BACK) || (op_r == OP_TRANSFER) ||
                    ((op_r == OP_PREPEND) && vld(hs) && vld(nxt_r[ci_r[IW-1:0]]));
    sts.walk_done = wend;
    sts.alloc_done = !used_r[cur_r] || (steps_r + SW'(1) >= neff);
    // destination still holds a chain once the source tail has been cut off
    sts.need_walk2 = (op_r == OP_TRANSFER) && vld(hd) &&
                     !((hs == wpos_r) && (lsi == dli));
    sts.clear_more = (op_r == OP_CLEAR) && vld(nxt_r[hs[IW-1:0]]) &&
                     (steps_r + SW'(1) < SW'(POOL_DEPTH));
  end

  // next values for the state registers
  always_comb begin
    logic [IW-1:0] c, p, n;
    logic [IW-1:0] cn;
    used_nxt = used_r;
    nxt_nxt = nxt_r;
    prv_nxt = prv_r;
    head_nxt = head_r;
    rotor_nxt = rotor_r;
    cur_nxt = cur_r;
    steps_nxt = steps_r;
    wpos_nxt = wpos_r;
    tail_nxt = tail_r;
    found_nxt = found_r;
    chunk_nxt = chunk_r;
    addr_nxt = addr_r;
    c = '0; p = '0; n = '0;
    cn = (32'(cur_r) + 1 >= 32'(neff)) ? '0 : IW'(32'(cur_r) + 1);
    if (cmd.load) begin
      found_nxt = 1'b1;
      chunk_nxt = '0;
      addr_nxt = '0;
    end
    if (cmd.walk_init) begin
      steps_nxt = '0;
      cur_nxt = (32'(rotor_r) >= 32'(neff)) ? '0 : rotor_r;
      if (op_r == OP_PREPEND) wpos_nxt = nxt_r[ci_r[IW-1:0]];
      else                    wpos_nxt = hs;
      if (op_r == OP_ALLOC) found_nxt = 1'b0;
    end
    if (cmd.alloc_step) begin
      if (!used_r[cur_r]) begin
        used_nxt[cur_r] = 1'b1;
        nxt_nxt[cur_r] = NIL;
        prv_nxt[cur_r] = NIL;
        found_nxt = 1'b1;
        chunk_nxt = 4'(cur_r);
        addr_nxt = base_r + 32'(cur_r) * CB;
        rotor_nxt = cn;
      end
      cur_nxt = cn;
      steps_nxt = steps_r + SW'(1);
    end
    if (cmd.walk_step && !wend) begin
      wpos_nxt = wnext;
      steps_nxt = steps_r + SW'(1);
    end
    if (cmd.exec) begin
      case (op_r)
        OP_POP_FRONT, OP_CLEAR: begin
          if (vld(hs)) begin
            c = hs[IW-1:0];
            if (vld(prv_r[c])) nxt_nxt[prv_r[c][IW-1:0]] = nxt_r[c];
            if (vld(nxt_r[c])) prv_nxt[nxt_r[c][IW-1:0]] = prv_r[c];
            used_nxt[c] = 1'b0;
            head_nxt[lsi] = nxt_r[c];
            steps_nxt = steps_r + SW'(1);
          end
        end
        OP_POP_BACK: begin
          c = wpos_r[IW-1:0];
          if (vld(prv_r[c])) nxt_nxt[prv_r[c][IW-1:0]] = NIL;
          if (hs == wpos_r) head_nxt[lsi] = NIL;
          used_nxt[c] = 1'b0;
        end
        OP_PREPEND: begin
          c = ci_r[IW-1:0];
          if (vld(hs)) begin
            if (vld(nxt_r[c])) begin
              nxt_nxt[wpos_r[IW-1:0]] = hs;
              prv_nxt[hs[IW-1:0]] = wpos_r;
            end else begin
              nxt_nxt[c] = hs;
              prv_nxt[hs[IW-1:0]] = ci_l;
            end
          end
          head_nxt[lsi] = ci_l;
        end
        OP_TRANSFER: begin
          c = wpos_r[IW-1:0];
          if (vld(prv_r[c])) nxt_nxt[prv_r[c][IW-1:0]] = NIL;
          prv_nxt[c] = NIL;
          nxt_nxt[c] = NIL;
          tail_nxt = wpos_r;
          if (hs == wpos_r) head_nxt[lsi] = NIL;
          if (!((hs != wpos_r || lsi != dli) && vld(hd)) ||
              (hs == wpos_r && lsi == dli)) begin
            head_nxt[dli] = wpos_r;
          end
        end
        default: c = '0;
      endcase
    end
    if (cmd.walk2_init) begin
      steps_nxt = '0;
      wpos_nxt = hd;
    end
    if (cmd.exec2) begin
      n = wpos_r[IW-1:0];
      p = tail_r[IW-1:0];
      nxt_nxt[n] = tail_r;
      prv_nxt[p] = wpos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        nxt_r[i] <= NIL;
        prv_r[i] <= NIL;
      end
      for (int j = 0; j < NUM_LISTS; j++) head_r[j] <= NIL;
      rotor_r <= '0;
      count_r <= 5'd16;
      base_r  <= '0;
    end else begin
      used_r <= used_nxt;
      nxt_r  <= nxt_nxt;
      prv_r  <= prv_nxt;
      head_r <= head_nxt;
      rotor_r <= rotor_nxt;
      if (cfg_we && cfg_idx == CFG_CHUNK_COUNT) count_r <= cfg_data[4:0];
      if (cfg_we && cfg_idx == CFG_BUFFER_BASE) base_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_in;
      ls_r <= list_in;
      dl_r <= dest_in;
      ci_r <= chunk_in;
    end
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
    wpos_r  <= wpos_nxt;
    tail_r  <= tail_nxt;
    found_r <= found_nxt;
    chunk_r <= chunk_nxt;
    addr_r  <= addr_nxt;
  end

  assign res_found = found_r;
  assign res_chunk = chunk_r;
  assign res_addr  = addr_r;

  // rotor always stays inside the pool
  a_rotor: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rotor_r) < 32'(POOL_DEPTH)) else $error("rotor out of range");
  // a successful allocation marks the chunk used
  a_alloc_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.alloc_step && !used_r[cur_r]) |=> used_r[$past(cur_r)])
    else $error("allocated chunk not marked");
  // walker bounded by pool depth
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> (32'(steps_r) <= 32'(POOL_DEPTH))) else $error("walk overran");
endmodule
`default_nettype wire

[rtl/core/chunk_pool_list_manager.sv]
// Top level of the chunk pool list manager: stream ports, output register.
// Depends on cplm_pkg, cplm_ctrl and cplm_dp.
//
// One transaction at a time. Allocate tests one chunk per cycle by the next-fit
// scan, up to chunk_count chunks; pop back, transfer and prepend onto a chain
// walk the next links one chunk per cycle, transfer walking both the source and
// the destination list; clear pops one chunk per cycle.
// The result is held in an output register; the next item is taken once the
// result has been written to it, while it may still wait to be handed on.
`default_nettype none
module chunk_pool_list_manager
  import cplm_pkg::*;
#(
  parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
  parameter int NUM_LISTS   = NUM_LISTS_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // opcode[2:0], list_sel[4:3], dest_list[6:5], chunk_in[10:7]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // found[0], chunk_out[4:1], buffer_address[36:5]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic busy;
  logic ov_r;
  logic res_found;
  logic [3:0] res_chunk;
  logic [31:0] res_addr;
  logic [39:0] od_r;

  assign in_tready = !busy;
  assign cfg_ready = 1'b1;

  cplm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_tvalid), .out_free(!ov_r || out_tready),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  cplm_dp #(.POOL_DEPTH(POOL_DEPTH), .NUM_LISTS(NUM_LISTS), .CHUNK_BYTES(CHUNK_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .op_in(in_tdata[2:0]), .list_in(in_tdata[4:3]), .dest_in(in_tdata[6:5]),
    .chunk_in(in_tdata[10:7]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index[0]), .cfg_data(cfg_data),
    .res_found(res_found), .res_chunk(res_chunk), .res_addr(res_addr)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.finish) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.finish) od_r <= {3'b000, res_addr, res_chunk, res_found};
  end
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r) else $error("result dropped");
endmodule
`default_nettype wire

[test/chunk_pool_list_manager_test.sv]
// Self-checking bench for the chunk pool list manager: directed table, then
// random list traffic, all results checked against an in-bench predictor.
// Depends on cplm_pkg and the chunk_pool_list_manager RTL.
`timescale 1ns / 1ps
`default_nettype none
module chunk_pool_list_manager_test;
  import cplm_pkg::*;

  localparam int DEPTH = 16;
  localparam int LISTS = 4;
  localparam int CBYTES = 32768;
  localparam logic [4:0] NUL = 5'd16;
  localparam longint CYCLE_LIMIT = 1500000;

  // packed from the top bit down, so opcode lands in the lowest bits
  typedef struct packed {
    logic [3:0] chunk;
    logic [1:0] dlist;
    logic [1:0] lsel;
    logic [2:0] op;
  } cmd_item_t;

  // packed from the top bit down, so found lands in bit 0
  typedef struct packed {
    logic [31:0] addr;
    logic [3:0]  chunk;
    logic        found;
  } grant_t;

  // directed row: command, whether the result is typed in, and that result
  typedef struct {
    cmd_item_t c;
    bit        fixed;
    grant_t    r;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  chunk_pool_list_manager dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  bit         used_q [DEPTH];
  logic [4:0] nxt_q [DEPTH];
  logic [4:0] prv_q [DEPTH];
  logic [4:0] head_q [LISTS];
  logic [3:0] rotor_q;
  logic [4:0] count_q;
  logic [31:0] base_q;

  grant_t pending_grants[$];
  int errors = 0;
  int results_seen = 0;
  int allocs_ok = 0, allocs_full = 0;
  longint cycles = 0;
  bit calm = 1'b0;    // no idling on either side while set

  function automatic bit is_chunk(logic [4:0] c);
    return c < NUL;
  endfunction

  function automatic logic [4:0] tail_of(logic [4:0] c);
    for (int s = 0; s < DEPTH; s++) begin
      if (!is_chunk(nxt_q[c])) break;
      c = nxt_q[c];
    end
    return c;
  endfunction

  function automatic void drop_head(int l);
    logic [4:0] c, p, n;
    c = head_q[l];
    if (!is_chunk(c)) return;
    p = prv_q[c];
    n = nxt_q[c];
    if (is_chunk(p)) nxt_q[p] = n;
    if (is_chunk(n)) prv_q[n] = p;
    used_q[c] = 1'b0;
    head_q[l] = n;
  endfunction

  // detach the tail of list l; returns it, or NUL when empty
  function automatic logic [4:0] cut_tail(int l);
    logic [4:0] c, p;
    if (!is_chunk(head_q[l])) return NUL;
    c = tail_of(head_q[l]);
    p = prv_q[c];
    if (is_chunk(p)) nxt_q[p] = NUL;
    if (head_q[l] == c) head_q[l] = NUL;
    return c;
  endfunction

  function automatic grant_t pool_predict(cmd_item_t c);
    grant_t g;
    int n, i;
    logic [4:0] t, e, h;
    g = '{found: 1'b1, chunk: 4'd0, addr: 32'd0};
    if (c.op == OP_ALLOC) begin
      n = (count_q == 0) ? 1 : (count_q > DEPTH) ? DEPTH : count_q;
      i = (rotor_q >= n) ? 0 : rotor_q;
      g.found = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (!used_q[i]) begin
          used_q[i] = 1'b1;
          nxt_q[i] = NUL;
          prv_q[i] = NUL;
          g.found = 1'b1;
          g.chunk = 4'(i);
          g.addr = base_q + 32'(i) * 32'(CBYTES);
          rotor_q = 4'((i + 1 >= n) ? 0 : i + 1);
          break;
        end
        i = (i + 1 >= n) ? 0 : i + 1;
      end
    end else if (c.op == OP_POP_FRONT) begin
      drop_head(c.lsel);
    end else if (c.op == OP_POP_BACK) begin
      t = cut_tail(c.lsel);
      if (is_chunk(t)) used_q[t] = 1'b0;
    end else if (c.op == OP_PREPEND) begin
      h = head_q[c.lsel];
      if (is_chunk(h)) begin
        e = is_chunk(nxt_q[c.chunk]) ? tail_of(nxt_q[c.chunk]) : {1'b0, c.chunk};
        nxt_q[e] = h;
        prv_q[h] = e;
      end
      head_q[c.lsel] = {1'b0, c.chunk};
    end else if (c.op == OP_TRANSFER) begin
      t = cut_tail(c.lsel);
      if (is_chunk(t)) begin
        prv_q[t] = NUL;
        nxt_q[t] = NUL;
        if (is_chunk(head_q[c.dlist])) begin
          e = tail_of(head_q[c.dlist]);
          nxt_q[e] = t;
          prv_q[t] = e;
        end else begin
          head_q[c.dlist] = t;
        end
      end
    end else if (c.op == OP_CLEAR) begin
      for (int k = 0; k < DEPTH && is_chunk(head_q[c.lsel]); k++) drop_head(c.lsel);
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
             what, got, want, results_seen);
  endtask

  // result side: random stalls, checks at the rising edge
  always @(posedge clk) begin
    grant_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[36:0];
      results_seen++;
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected result", got.addr, 32'd0);
      end else begin
        want = pending_grants.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.chunk !== want.chunk)
          report_mismatch("chunk_out", 32'(got.chunk), 32'(want.chunk));
        if (got.addr !== want.addr) report_mismatch("buffer_address", got.addr, want.addr);
      end
    end
  end

  always @(negedge clk) out_tready <= calm || ($urandom_range(99) >= 28);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("chunk_pool_list_manager_test: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHUNK_COUNT) count_q = val[4:0];
    else base_q = val;
  endtask

  // wait for every result, then a quiet spell
  task automatic drain();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);
  endtask

  // offer one transaction with a random gap beforehand; the predictor runs at acceptance
  task automatic send_item(cmd_item_t c, bit fixed, grant_t r);
    grant_t g;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, c};
    do @(posedge clk); while (!in_tready);
    g = pool_predict(c);
    if (c.op == OP_ALLOC) begin
      if (g.found) allocs_ok++;
      else allocs_full++;
    end
    if (fixed && g !== r)
      report_mismatch("directed row", 32'({g.chunk, g.found}), 32'({r.chunk, r.found}));
    pending_grants.push_back(fixed ? r : g);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic cmd_item_t mk(logic [2:0] op, int l, int d, int ch);
    cmd_item_t c;
    c.op = op;
    c.lsel = 2'(l);
    c.dlist = 2'(d);
    c.chunk = 4'(ch);
    return c;
  endfunction

  function automatic grant_t gr(bit f, int ch, logic [31:0] a);
    grant_t g;
    g.found = f;
    g.chunk = 4'(ch);
    g.addr = a;
    return g;
  endfunction

  task automatic random_phase(int items);
    cmd_item_t c;
    int pick;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      c = 11'($urandom);
      // mostly allocate and list traffic, a few unused opcodes
      if (pick < 35) c.op = OP_ALLOC;
      else if (pick < 50) c.op = OP_PREPEND;
      else if (pick < 62) c.op = OP_TRANSFER;
      else if (pick < 74) c.op = OP_POP_FRONT;
      else if (pick < 86) c.op = OP_POP_BACK;
      else if (pick < 92) c.op = OP_CLEAR;
      else if (pick < 96) c.op = 3'($urandom_range(7, 6));
      else c.op = 3'($urandom_range(5));
      send_item(c, 1'b0, '0);
    end
  endtask

  row_t plan[$];

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      used_q[i] = 1'b0;
      nxt_q[i] = NUL;
      prv_q[i] = NUL;
    end
    for (int l = 0; l < LISTS; l++) head_q[l] = NUL;
    rotor_q = 0;
    count_q = 5'd16;
    base_q = 32'd0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drain();

    // directed: after reset defaults, then list ops, edges and unused codes
    plan = '{
      '{mk(OP_ALLOC, 0, 0, 0), 1'b1, gr(1, 0, 32'h0)},
      '{mk(OP_ALLOC, 0, 0, 0), 1'b1, gr(1, 1, 32'h8000)},
      '{mk(OP_ALLOC, 0, 0, 0), 1'b1, gr(1, 2, 32'h10000)},
      '{mk(OP_PREPEND, 0, 0, 0), 1'b1, gr(1, 0, 0)},
      '{mk(OP_PREPEND, 0, 0, 1), 1'b1, gr(1, 0, 0)},
      '{mk(OP_PREPEND, 3, 0, 2), 1'b1, gr(1, 0, 0)},
      '{mk(OP_TRANSFER, 0, 3, 0), 1'b1, gr(1, 0, 0)},
      '{mk(OP_POP_BACK, 3, 0, 0), 1'b0, '0},
      '{mk(OP_POP_FRONT, 0, 0, 0), 1'b0, '0},
      '{mk(OP_PREPEND, 1, 0, 15), 1'b1, gr(1, 0, 0)},
      '{mk(OP_PREPEND, 2, 0, 2), 1'b0, '0},
      '{mk(OP_TRANSFER, 2, 2, 0), 1'b0, '0},
      '{mk(OP_CLEAR, 3, 0, 0), 1'b1, gr(1, 0, 0)},
      '{mk(OP_CLEAR, 1, 0, 0), 1'b1, gr(1, 0, 0)},
      '{mk(OP_POP_FRONT, 2, 0, 0), 1'b0, '0},
      '{mk(OP_POP_BACK, 0, 0, 0), 1'b0, '0},
      '{mk(3'd6, 3, 3, 15), 1'b1, gr(1, 0, 0)},
      '{mk(3'd7, 2, 1, 7), 1'b1, gr(1, 0, 0)},
      '{mk(OP_ALLOC, 3, 3, 15), 1'b0, '0}
    };
    foreach (plan[i]) send_item(plan[i].c, plan[i].fixed, plan[i].r);
    drain();

    // smallest pool, top base: second allocate must miss
    write_reg(CFG_CHUNK_COUNT, 32'd1);
    write_reg(CFG_BUFFER_BASE, 32'hFFFF_FFFF);
    send_item(mk(OP_CLEAR, 0, 0, 0), 1'b0, '0);
    send_item(mk(OP_CLEAR, 2, 0, 0), 1'b0, '0);
    send_item(mk(OP_ALLOC, 0, 0, 0), 1'b0, '0);
    send_item(mk(OP_ALLOC, 0, 0, 0), 1'b0, '0);
    drain();

    // random phases over several pool settings, one with no idling
    write_reg(CFG_CHUNK_COUNT, 32'd0);
    write_reg(CFG_BUFFER_BASE, 32'h8000_0000);
    random_phase(200);
    drain();
    write_reg(CFG_CHUNK_COUNT, 32'd31);
    write_reg(CFG_BUFFER_BASE, $urandom);
    random_phase(300);
    drain();
    write_reg(CFG_CHUNK_COUNT, 32'd16);
    write_reg(CFG_BUFFER_BASE, 32'h0);
    calm = 1'b1;
    random_phase(300);
    calm = 1'b0;
    drain();
    write_reg(CFG_CHUNK_COUNT, 32'($urandom_range(2, 15)));
    write_reg(CFG_BUFFER_BASE, $urandom);
    random_phase(350);
    drain();
    write_reg(CFG_CHUNK_COUNT, 32'd5);
    write_reg(CFG_BUFFER_BASE, 32'hFFFF_0000);
    random_phase(330);
    drain();

    $display("covered %0d results: %0d allocations granted, %0d refused (pool full),",
             results_seen, allocs_ok, allocs_full);
    $display("with pop, prepend, transfer and clear traffic over six pool settings");
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("chunk_pool_list_manager_test: clean");
    end else begin
      $display("chunk_pool_list_manager_test: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
